[rtl/drup_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drup_pkg
// shared types and codes for the discounted regret update core
// ----------------------------------------------------------------------------
package drup_pkg;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned QW      = 17;   // width of a q1.16 probability
  localparam int unsigned CFG_W   = 17;   // widest config register

  localparam logic [1:0] REQ_UPDATE  = 2'd0;
  localparam logic [1:0] REQ_CURRENT = 2'd1;
  localparam logic [1:0] REQ_AVERAGE = 2'd2;

  localparam logic [2:0] CFG_ACTION_COUNT = 3'd0;
  localparam logic [2:0] CFG_HAND_COUNT   = 3'd1;
  localparam logic [2:0] CFG_POS_DISCOUNT = 3'd2;
  localparam logic [2:0] CFG_NEG_DISCOUNT = 3'd3;
  localparam logic [2:0] CFG_CUM_DECAY    = 3'd4;
  localparam logic [2:0] CFG_STRAT_WEIGHT = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         action_index;
    logic [10:0]        hand_index;
    logic signed [31:0] regret_value;
    logic               last_of_iteration;
  } req_t;

  typedef struct packed {
    logic [16:0] strategy_value;
    logic        status;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/drup_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drup_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module drup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/discounted_regret_update_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// discounted_regret_update_core
// regret and cumulative strategy store with regret matching for one node
// ----------------------------------------------------------------------------
// an update flagged last also runs a pass over every live hand before its result
// throughput: one beat in flight at a time, the result register frees the
//   input side; the single ram read port and the 17-step divider set the pace
// reset: clears control, then sweeps all 2^(clog2(MAX_ACTIONS)+clog2(MAX_HANDS))
//   entries (16384 by default) zeroing both tables; no beat taken meanwhile
module discounted_regret_update_core #(
  parameter int MAX_ACTIONS = 8,
  parameter int MAX_HANDS   = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire drup_pkg::req_t           in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output drup_pkg::rsp_t                out_data,
  input  wire logic                     cfg_write,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [drup_pkg::CFG_W-1:0] cfg_data
);

  // widths derived from the table geometry
  localparam int AW    = $clog2(MAX_ACTIONS);
  localparam int HW    = (MAX_HANDS > 1) ? $clog2(MAX_HANDS) : 1;
  localparam int EW    = AW + HW;
  localparam int DEPTH = 2 ** EW;
  localparam int CW    = $clog2(MAX_ACTIONS + 1);
  localparam int HCW   = $clog2(MAX_HANDS + 1);
  localparam int SW    = 32 + AW;            // sum of up to MAX_ACTIONS words
  localparam int QW    = drup_pkg::QW;

  // sequencer states
  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_UPD_RD   = 4'd2;
  localparam logic [3:0] ST_UPD_MUL  = 4'd3;
  localparam logic [3:0] ST_UPD_WR   = 4'd4;
  localparam logic [3:0] ST_SUM_RD   = 4'd5;
  localparam logic [3:0] ST_SUM_ACC  = 4'd6;
  localparam logic [3:0] ST_SUM_END  = 4'd7;
  localparam logic [3:0] ST_DIV      = 4'd8;
  localparam logic [3:0] ST_DIV_END  = 4'd9;
  localparam logic [3:0] ST_P_RD     = 4'd10;
  localparam logic [3:0] ST_P_SHARE  = 4'd11;
  localparam logic [3:0] ST_P_MUL    = 4'd12;
  localparam logic [3:0] ST_P_WR     = 4'd13;
  localparam logic [3:0] ST_RESP     = 4'd14;

  // operation in progress
  localparam logic [1:0] OP_UPD  = 2'd0;
  localparam logic [1:0] OP_CUR  = 2'd1;
  localparam logic [1:0] OP_AVG  = 2'd2;
  localparam logic [1:0] OP_PASS = 2'd3;

  // configuration registers
  logic [3:0]  action_count;
  logic [11:0] hand_count;
  logic [16:0] positive_discount;
  logic [16:0] negative_discount;
  logic [16:0] cumulative_decay;
  logic [16:0] strategy_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      action_count      <= 4'd2;
      hand_count        <= 12'd2048;
      positive_discount <= 17'd32768;
      negative_discount <= 17'd32768;
      cumulative_decay  <= 17'd65536;
      strategy_weight   <= 17'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        drup_pkg::CFG_ACTION_COUNT: action_count      <= cfg_data[3:0];
        drup_pkg::CFG_HAND_COUNT:   hand_count        <= cfg_data[11:0];
        drup_pkg::CFG_POS_DISCOUNT: positive_discount <= cfg_data;
        drup_pkg::CFG_NEG_DISCOUNT: negative_discount <= cfg_data;
        drup_pkg::CFG_CUM_DECAY:    cumulative_decay  <= cfg_data;
        drup_pkg::CFG_STRAT_WEIGHT: strategy_weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, clamp to the table size
  logic [CW-1:0]  na;
  logic [HCW-1:0] nh;

  always_comb begin
    if (action_count == 4'd0) begin
      na = CW'(1);
    end else if (32'(action_count) > 32'(MAX_ACTIONS)) begin
      na = CW'(MAX_ACTIONS);
    end else begin
      na = CW'(action_count);
    end
    if (hand_count == 12'd0) begin
      nh = HCW'(1);
    end else if (32'(hand_count) > 32'(MAX_HANDS)) begin
      nh = HCW'(MAX_HANDS);
    end else begin
      nh = HCW'(hand_count);
    end
  end

  // sequencer registers
  logic [3:0]        state;
  logic [1:0]        op;
  logic [EW-1:0]     clr_cnt;
  logic [AW-1:0]     a_sel;
  logic [HW-1:0]     h_sel;
  logic signed [31:0] upd_regret;
  logic              upd_last;
  logic [CW-1:0]     k;
  logic [HCW-1:0]    ph;
  logic [SW-1:0]     acc;
  logic [31:0]       tgt;
  logic [31:0]       cum_hold;
  logic [QW-1:0]     share;
  logic signed [50:0] upd_prod;
  logic [48:0]       cum_prod;
  logic [33:0]       str_prod;
  logic [QW-1:0]     res_val;
  logic              res_st;

  // shared restoring divider, numerator never above denominator
  logic [SW:0]       div_rem;
  logic [SW-1:0]     div_den;
  logic [QW-1:0]     div_q;
  logic [4:0]        div_cnt;

  // memories
  logic              rg_we;
  logic [EW-1:0]     rg_waddr;
  logic [31:0]       rg_wdata;
  logic [31:0]       rg_rdata;
  logic              cm_we;
  logic [EW-1:0]     cm_waddr;
  logic [31:0]       cm_wdata;
  logic [31:0]       cm_rdata;
  logic [EW-1:0]     raddr;

  drup_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_regret_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (raddr),
    .rdata (rg_rdata)
  );

  drup_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cum_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (raddr),
    .rdata (cm_rdata)
  );

  // combinational helpers
  logic signed [31:0] rg_s;
  logic               in_ok;
  logic               accept;
  logic [HW-1:0]      h_cur;
  logic signed [32:0] upd_sum;
  logic signed [17:0] upd_f;
  logic signed [50:0] upd_prod_next;
  logic signed [34:0] upd_q;
  logic [31:0]        upd_sat;
  logic [33:0]        cum_v;
  logic [31:0]        cum_sat;
  logic               div_ge;
  logic [SW:0]        div_t;
  logic [SW-1:0]      acc_add;

  assign rg_s     = $signed(rg_rdata);
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_ok    = (32'(in_data.action_index) < 32'(na)) &&
                    (32'(in_data.hand_index) < 32'(nh));
  assign h_cur    = (op == OP_PASS) ? ph[HW-1:0] : h_sel;

  always_comb begin
    unique case (state)
      ST_SUM_RD: raddr = {k[AW-1:0], h_cur};
      ST_P_RD:   raddr = {k[AW-1:0], ph[HW-1:0]};
      default:   raddr = {a_sel, h_sel};
    endcase
  end

  // regret update arithmetic: exact sum, discount, floor shift, saturate
  always_comb begin
    upd_sum       = 33'(rg_s) + 33'(upd_regret);
    upd_f         = (upd_sum > 33'sd0) ? $signed({1'b0, positive_discount})
                                       : $signed({1'b0, negative_discount});
    upd_prod_next = 51'(upd_sum) * 51'(upd_f);
    upd_q         = upd_prod[50:16];
    if (upd_q[34:31] == 4'b0000 || upd_q[34:31] == 4'b1111) begin
      upd_sat = upd_q[31:0];
    end else if (upd_q[34]) begin
      upd_sat = 32'h8000_0000;
    end else begin
      upd_sat = 32'h7FFF_FFFF;
    end
  end

  // cumulative fold: decayed old weight plus weighted share, saturating
  always_comb begin
    cum_v   = {1'b0, cum_prod[48:16]} + 34'(str_prod[33:16]);
    cum_sat = (cum_v[33:32] != 2'b00) ? 32'hFFFF_FFFF : cum_v[31:0];
  end

  // one divider step
  always_comb begin
    div_ge = div_rem >= {1'b0, div_den};
    div_t  = div_ge ? (div_rem - {1'b0, div_den}) : div_rem;
  end

  // contribution of the word just read to the running sum
  always_comb begin
    if (op == OP_AVG) begin
      acc_add = SW'(cm_rdata);
    end else if (rg_s > 32'sd0) begin
      acc_add = SW'(rg_rdata);
    end else begin
      acc_add = '0;
    end
  end

  // ram write ports
  always_comb begin
    rg_we    = (state == ST_CLEAR) || (state == ST_UPD_WR);
    rg_waddr = (state == ST_CLEAR) ? clr_cnt : {a_sel, h_sel};
    rg_wdata = (state == ST_CLEAR) ? 32'd0 : upd_sat;
    cm_we    = (state == ST_CLEAR) || (state == ST_P_WR);
    cm_waddr = (state == ST_CLEAR) ? clr_cnt : {k[AW-1:0], ph[HW-1:0]};
    cm_wdata = (state == ST_CLEAR) ? 32'd0 : cum_sat;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      op        <= OP_UPD;
      k         <= '0;
      ph        <= '0;
      div_cnt   <= '0;
    end else begin
      // result taken; the response state reloads the register itself
      if (out_valid && out_ready && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + EW'(1);
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            a_sel      <= AW'(in_data.action_index);
            h_sel      <= HW'(in_data.hand_index);
            upd_regret <= in_data.regret_value;
            upd_last   <= in_data.last_of_iteration;
            res_val    <= '0;
            k          <= '0;
            acc        <= '0;
            tgt        <= '0;
            case (in_data.req_type)
              drup_pkg::REQ_UPDATE: begin
                res_st <= !in_ok;
                if (in_ok) begin
                  op    <= OP_UPD;
                  state <= ST_UPD_RD;
                end else if (in_data.last_of_iteration) begin
                  op    <= OP_PASS;
                  ph    <= '0;
                  state <= ST_SUM_RD;
                end else begin
                  op    <= OP_UPD;
                  state <= ST_RESP;
                end
              end
              drup_pkg::REQ_CURRENT, drup_pkg::REQ_AVERAGE: begin
                op <= (in_data.req_type == drup_pkg::REQ_CURRENT) ? OP_CUR : OP_AVG;
                res_st <= !in_ok;
                if (in_ok) begin
                  state <= ST_SUM_RD;
                end else begin
                  state <= ST_RESP;
                end
              end
              default: begin
                res_st <= 1'b1;
                state  <= ST_RESP;
              end
            endcase
          end
        end

        ST_UPD_RD: state <= ST_UPD_MUL;

        ST_UPD_MUL: begin
          upd_prod <= upd_prod_next;
          state    <= ST_UPD_WR;
        end

        ST_UPD_WR: begin
          if (upd_last) begin
            op    <= OP_PASS;
            ph    <= '0;
            k     <= '0;
            acc   <= '0;
            state <= ST_SUM_RD;
          end else begin
            state <= ST_RESP;
          end
        end

        // walk the actions of one hand, summing positive regret or weight
        ST_SUM_RD: state <= ST_SUM_ACC;

        ST_SUM_ACC: begin
          acc <= acc + acc_add;
          if (op != OP_PASS && k[AW-1:0] == a_sel) begin
            tgt <= (op == OP_AVG) ? cm_rdata : rg_rdata;
          end
          if (k == na - CW'(1)) begin
            k     <= '0;
            state <= ST_SUM_END;
          end else begin
            k     <= k + CW'(1);
            state <= ST_SUM_RD;
          end
        end

        ST_SUM_END: begin
          if (op == OP_PASS) begin
            state <= ST_P_RD;
          end else begin
            div_cnt <= '0;
            div_q   <= '0;
            if (acc == '0) begin
              div_rem <= (SW+1)'(1);
              div_den <= SW'(na);
              state   <= ST_DIV;
            end else if (op == OP_CUR && $signed(tgt) <= 32'sd0) begin
              res_val <= '0;
              state   <= ST_RESP;
            end else begin
              div_rem <= (SW+1)'(tgt);
              div_den <= acc;
              state   <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          div_rem <= {div_t[SW-1:0], 1'b0};
          div_q   <= {div_q[QW-2:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(QW - 1)) begin
            state <= ST_DIV_END;
          end
        end

        ST_DIV_END: begin
          if (op == OP_PASS) begin
            share <= div_q;
            state <= ST_P_MUL;
          end else begin
            res_val <= div_q;
            state   <= ST_RESP;
          end
        end

        // per entry of the pass: share, then fold into the cumulative table
        ST_P_RD: state <= ST_P_SHARE;

        ST_P_SHARE: begin
          cum_hold <= cm_rdata;
          div_cnt  <= '0;
          div_q    <= '0;
          if (acc == '0) begin
            div_rem <= (SW+1)'(1);
            div_den <= SW'(na);
            state   <= ST_DIV;
          end else if (rg_s <= 32'sd0) begin
            share <= '0;
            state <= ST_P_MUL;
          end else begin
            div_rem <= (SW+1)'(rg_rdata);
            div_den <= acc;
            state   <= ST_DIV;
          end
        end

        ST_P_MUL: begin
          cum_prod <= 49'(cum_hold) * 49'(cumulative_decay);
          str_prod <= 34'(share) * 34'(strategy_weight);
          state    <= ST_P_WR;
        end

        ST_P_WR: begin
          if (k == na - CW'(1)) begin
            k   <= '0;
            acc <= '0;
            if (ph == nh - HCW'(1)) begin
              state <= ST_RESP;
            end else begin
              ph    <= ph + HCW'(1);
              state <= ST_SUM_RD;
            end
          end else begin
            k     <= k + CW'(1);
            state <= ST_P_RD;
          end
        end

        ST_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.strategy_value <= res_val;
            out_data.status         <= res_st;
            state                   <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/drup_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drup_checker
// port level checks on the discounted regret update core
// ----------------------------------------------------------------------------
module drup_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire drup_pkg::req_t in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire drup_pkg::rsp_t out_data
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an error result never carries a probability
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.strategy_value == 17'd0)
    else $error("error beat with non-zero value");

  // probability never exceeds one
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.strategy_value <= 17'd65536)
    else $error("probability above one");

  // table sweep after reset keeps the input closed
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open during clearing sweep");

  // one beat in flight at a time
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

endmodule

bind discounted_regret_update_core drup_checker u_drup_checker (.*);
`default_nettype wire

[tb/sv/tb_discounted_regret_update_core.sv]
// ----------------------------------------------------------------------------
// tb_discounted_regret_update_core
// self-checking bench for the discounted regret update core: a behavioural
// copy of both tables predicts every result beat, directed cases cover
// extremes, clamped counts, error paths and back-pressure, then random phases
// sweep the discount, decay and weight registers
// ----------------------------------------------------------------------------
module tb_discounted_regret_update_core;

  localparam int NA_MAX    = 8;
  localparam int NH_MAX    = 2048;
  localparam int DEPTH     = NA_MAX * NH_MAX;
  localparam int CYCLE_CAP = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  drup_pkg::req_t in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  drup_pkg::rsp_t out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [drup_pkg::CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  discounted_regret_update_core #(.MAX_ACTIONS(NA_MAX), .MAX_HANDS(NH_MAX)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the block's registers and tables
  logic [3:0]  action_cnt;
  logic [11:0] hand_cnt;
  logic [16:0] pos_disc, neg_disc, cum_decay, strat_weight;
  int signed   regret_mem [DEPTH];
  logic [31:0] weight_mem [DEPTH];

  drup_pkg::rsp_t pending_rsp[$];
  int    errors;
  int    beats_sent;
  int    beats_checked;
  int    passes_run;
  int    cycles;
  bit    calm;          // no idling on either side
  int    hold_off;      // receiver stall, counted down on its own

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int live_actions();
    int c;
    c = action_cnt;
    if (c == 0) c = 1;
    if (c > NA_MAX) c = NA_MAX;
    return c;
  endfunction

  function automatic int live_hands();
    int c;
    c = hand_cnt;
    if (c == 0) c = 1;
    if (c > NH_MAX) c = NH_MAX;
    return c;
  endfunction

  function automatic longint unsigned hand_positive_sum(int h, int na);
    longint unsigned s;
    s = 0;
    for (int a = 0; a < na; a++)
      if (regret_mem[a*NH_MAX + h] > 0) s += longint'(regret_mem[a*NH_MAX + h]);
    return s;
  endfunction

  function automatic logic [16:0] matched_share(int signed r, longint unsigned s, int na);
    longint unsigned q;
    if (s == 0) return 17'(drup_pkg::ONE_Q16 / na);
    if (r <= 0) return '0;
    q = (longint'(r) << 16) / s;
    return q[16:0];
  endfunction

  // end-of-iteration fold of the matched strategy into the cumulative weights
  task automatic fold_iteration();
    int na, nh, e;
    longint unsigned s, v;
    logic [16:0] st;
    na = live_actions();
    nh = live_hands();
    for (int h = 0; h < nh; h++) begin
      s = hand_positive_sum(h, na);
      for (int a = 0; a < na; a++) begin
        e  = a*NH_MAX + h;
        st = matched_share(regret_mem[e], s, na);
        v  = ((longint'(weight_mem[e]) * longint'(cum_decay)) >> 16)
           + ((longint'(st) * longint'(strat_weight)) >> 16);
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        weight_mem[e] = v[31:0];
      end
    end
    passes_run++;
  endtask

  task automatic predict_beat(drup_pkg::req_t r);
    drup_pkg::rsp_t o;
    int na, nh, e;
    bit ok;
    longint sum, p;
    longint unsigned s, q;
    o  = '0;
    na = live_actions();
    nh = live_hands();
    ok = (r.action_index < na) && (r.hand_index < nh);
    e  = r.action_index * NH_MAX + r.hand_index;
    case (r.req_type)
      drup_pkg::REQ_UPDATE: begin
        if (ok) begin
          sum = longint'(regret_mem[e]) + longint'(r.regret_value);
          p   = sum * longint'(sum > 0 ? pos_disc : neg_disc);
          p   = p >>> 16;   // floor toward minus infinity
          if (p > 64'sd2147483647) p = 64'sd2147483647;
          if (p < -64'sd2147483648) p = -64'sd2147483648;
          regret_mem[e] = int'(p);
        end else begin
          o.status = 1'b1;
        end
        if (r.last_of_iteration) fold_iteration();
      end
      drup_pkg::REQ_CURRENT: begin
        if (ok) o.strategy_value = matched_share(regret_mem[e],
                                                 hand_positive_sum(r.hand_index, na), na);
        else o.status = 1'b1;
      end
      drup_pkg::REQ_AVERAGE: begin
        if (ok) begin
          s = 0;
          for (int a = 0; a < na; a++) s += weight_mem[a*NH_MAX + r.hand_index];
          if (s == 0) begin
            o.strategy_value = 17'(drup_pkg::ONE_Q16 / na);
          end else begin
            q = (longint'(weight_mem[e]) << 16) / s;
            o.strategy_value = q[16:0];
          end
        end else begin
          o.status = 1'b1;
        end
      end
      default: o.status = 1'b1;  // unknown request
    endcase
    pending_rsp = {pending_rsp, o};
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one input beat; valid may idle first, then holds until accepted
  task automatic send_beat(drup_pkg::req_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    do @(posedge clk); while (!in_ready);
    predict_beat(r);
    beats_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait for every expected beat, then a margin so the block is idle
  task automatic drain();
    end_burst();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [drup_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      drup_pkg::CFG_ACTION_COUNT: action_cnt   = val[3:0];
      drup_pkg::CFG_HAND_COUNT:   hand_cnt     = val[11:0];
      drup_pkg::CFG_POS_DISCOUNT: pos_disc     = val[16:0];
      drup_pkg::CFG_NEG_DISCOUNT: neg_disc     = val[16:0];
      drup_pkg::CFG_CUM_DECAY:    cum_decay    = val[16:0];
      drup_pkg::CFG_STRAT_WEIGHT: strat_weight = val[16:0];
      default: ;
    endcase
  endtask

  function automatic drup_pkg::req_t make_req(logic [1:0] kind, int a, int h,
                                              logic signed [31:0] r, bit last);
    drup_pkg::req_t q;
    q.req_type          = kind;
    q.action_index      = 3'(a);
    q.hand_index        = 11'(h);
    q.regret_value      = r;
    q.last_of_iteration = last;
    return q;
  endfunction

  function automatic logic [16:0] pick_factor();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(65536, 16384));
    endcase
  endfunction

  // random beat: mostly in range updates and reads, some noise and errors
  function automatic drup_pkg::req_t random_req();
    drup_pkg::req_t q;
    int   sel;
    q.req_type          = 2'($urandom_range(2));
    q.action_index      = 3'($urandom_range(live_actions() - 1));
    q.hand_index        = 11'($urandom_range(live_hands() - 1));
    sel = $urandom_range(99);
    if (sel < 60)      q.regret_value = $signed(32'($urandom_range(2000000))) - 32'sd1000000;
    else if (sel < 85) q.regret_value = $urandom;
    else               q.regret_value = (sel & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    q.last_of_iteration = ($urandom_range(99) < 4) ? 1'b1 : ($urandom_range(1) == 1 &&
                          q.req_type != drup_pkg::REQ_UPDATE);
    sel = $urandom_range(99);
    if (sel < 8)       q.action_index = 3'($urandom);
    else if (sel < 16) q.hand_index   = 11'($urandom);
    else if (sel < 19) q.req_type     = 2'd3;
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver and result check
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready = 1'b0;
      hold_off  = hold_off - 1;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    drup_pkg::rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result beat with none expected: value %0d status %0d",
                 $time, out_data.strategy_value, out_data.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.strategy_value !== want.strategy_value) begin
          $display("%0t: strategy_value expected %0d actual %0d",
                   $time, want.strategy_value, out_data.strategy_value);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        beats_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("discounted_regret_update_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // fresh tables read back uniform for both strategies
  task automatic test_reset_state();
    send_beat(make_req(drup_pkg::REQ_CURRENT, 0, 0, 0, 1'b0));
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 1, 2047, 0, 1'b1));
    drain();
  endtask

  // field extremes, saturation, error paths, unknown request
  task automatic test_extremes();
    write_reg(drup_pkg::CFG_ACTION_COUNT, 17'd8);
    write_reg(drup_pkg::CFG_HAND_COUNT, 17'd4);
    write_reg(drup_pkg::CFG_POS_DISCOUNT, 17'h1FFFF);
    write_reg(drup_pkg::CFG_NEG_DISCOUNT, 17'h1FFFF);
    write_reg(drup_pkg::CFG_CUM_DECAY, 17'h1FFFF);
    write_reg(drup_pkg::CFG_STRAT_WEIGHT, 17'h1FFFF);
    send_beat(make_req(drup_pkg::REQ_UPDATE, 7, 3, 32'sh7FFF_FFFF, 1'b0));
    send_beat(make_req(drup_pkg::REQ_UPDATE, 7, 3, 32'sh7FFF_FFFF, 1'b0)); // saturates high
    send_beat(make_req(drup_pkg::REQ_UPDATE, 0, 0, 32'sh8000_0000, 1'b0));
    send_beat(make_req(drup_pkg::REQ_UPDATE, 0, 0, 32'sh8000_0000, 1'b0)); // saturates low
    send_beat(make_req(drup_pkg::REQ_UPDATE, 1, 3, 32'sd1, 1'b0));
    send_beat(make_req(drup_pkg::REQ_UPDATE, 2, 3, -32'sd1, 1'b1));
    send_beat(make_req(drup_pkg::REQ_CURRENT, 7, 3, 0, 1'b1));     // flag ignored on reads
    send_beat(make_req(drup_pkg::REQ_CURRENT, 1, 3, 0, 1'b0));
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 7, 3, 0, 1'b0));
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 0, 0, 0, 1'b0));
    send_beat(make_req(drup_pkg::REQ_UPDATE, 0, 2047, 5, 1'b1));   // bad hand, pass still runs
    send_beat(make_req(drup_pkg::REQ_CURRENT, 0, 4, 0, 1'b0));
    send_beat(make_req(2'd3, 7, 2047, 32'shFFFF_FFFF, 1'b1));      // unknown request
    drain();
    write_reg(drup_pkg::CFG_POS_DISCOUNT, 17'd0);
    write_reg(drup_pkg::CFG_NEG_DISCOUNT, 17'd0);
    write_reg(drup_pkg::CFG_CUM_DECAY, 17'd0);
    write_reg(drup_pkg::CFG_STRAT_WEIGHT, 17'd0);
    send_beat(make_req(drup_pkg::REQ_UPDATE, 7, 3, 32'sd12345, 1'b1)); // everything zeroed
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 7, 3, 0, 1'b0));
    send_beat(make_req(drup_pkg::REQ_CURRENT, 0, 0, 0, 1'b0));
    drain();
  endtask

  // zero counts act as one, oversized counts clamp to the maxima
  task automatic test_count_clamps();
    write_reg(drup_pkg::CFG_ACTION_COUNT, 17'd0);
    write_reg(drup_pkg::CFG_HAND_COUNT, 17'd0);
    write_reg(drup_pkg::CFG_CUM_DECAY, 17'd65536);
    write_reg(drup_pkg::CFG_STRAT_WEIGHT, 17'd65536);
    send_beat(make_req(drup_pkg::REQ_UPDATE, 1, 0, 32'sd100, 1'b0)); // action beyond one
    send_beat(make_req(drup_pkg::REQ_UPDATE, 0, 1, 32'sd100, 1'b1)); // hand beyond one
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 0, 0, 0, 1'b0));
    drain();
    write_reg(drup_pkg::CFG_ACTION_COUNT, 17'd15);
    write_reg(drup_pkg::CFG_HAND_COUNT, 17'd3);
    send_beat(make_req(drup_pkg::REQ_UPDATE, 7, 2, 32'sd70000, 1'b0));
    send_beat(make_req(drup_pkg::REQ_CURRENT, 7, 2, 0, 1'b0));
    drain();
    // full hand range once, one action so the pass stays short
    write_reg(drup_pkg::CFG_ACTION_COUNT, 17'd1);
    write_reg(drup_pkg::CFG_HAND_COUNT, 17'hFFF);
    send_beat(make_req(drup_pkg::REQ_UPDATE, 0, 2047, -32'sd4000, 1'b1));
    send_beat(make_req(drup_pkg::REQ_AVERAGE, 0, 2047, 0, 1'b0));
    drain();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    write_reg(drup_pkg::CFG_ACTION_COUNT, 17'd4);
    write_reg(drup_pkg::CFG_HAND_COUNT, 17'd6);
    calm     = 1'b1;
    hold_off = 600;
    repeat (20) send_beat(random_req());
    calm = 1'b0;
    drain();
  endtask

  task automatic test_random_phases(int beats_total);
    int per_phase;
    per_phase = beats_total / 6;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(drup_pkg::CFG_ACTION_COUNT, (ph == 0) ? 17'd8 : 17'($urandom_range(15)));
      write_reg(drup_pkg::CFG_HAND_COUNT, (ph == 5) ? 17'd1 : 17'($urandom_range(12)));
      write_reg(drup_pkg::CFG_POS_DISCOUNT, (ph == 1) ? 17'h1FFFF : pick_factor());
      write_reg(drup_pkg::CFG_NEG_DISCOUNT, (ph == 1) ? 17'd0 : pick_factor());
      write_reg(drup_pkg::CFG_CUM_DECAY, (ph == 2) ? 17'h1FFFF : pick_factor());
      write_reg(drup_pkg::CFG_STRAT_WEIGHT, (ph == 2) ? 17'h1FFFF : pick_factor());
      calm = (ph == 0);   // first phase runs flat out on both sides
      repeat (per_phase) send_beat(random_req());
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    action_cnt    = 4'd2;
    hand_cnt      = 12'd2048;
    pos_disc      = 17'd32768;
    neg_disc      = 17'd32768;
    cum_decay     = 17'd65536;
    strat_weight  = 17'd65536;
    for (int i = 0; i < DEPTH; i++) begin
      regret_mem[i] = 0;
      weight_mem[i] = '0;
    end
    errors = 0; beats_sent = 0; beats_checked = 0; passes_run = 0;
    cycles = 0; calm = 1'b0; hold_off = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_extremes();
    test_count_clamps();
    test_backpressure();
    test_random_phases(1600);

    $display("covered %0d beats (%0d checked) and %0d iteration passes",
             beats_sent, beats_checked, passes_run);
    $display("settings swept: zero, unit and saturating factors, clamped counts");
    if (errors == 0) begin
      $display("discounted_regret_update_core regression: pass");
    end else begin
      $display("discounted_regret_update_core regression: fail");
    end
    $finish;
  end

endmodule
